FILE: hdl/tabular_q_learning_engine_macros.svh
// assertion macros for the tabular q-learning engine
// used by the top level; expects clk_i and rst_ni in scope
`ifndef TABULAR_Q_LEARNING_ENGINE_MACROS_SVH
`define TABULAR_Q_LEARNING_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define TQLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TQLE_ASSERT_NEXT(lbl, pre, post, msg) \
  `TQLE_ASSERT(lbl, pre |=> post, msg)
`else
`define TQLE_ASSERT(lbl, prop, msg)
`define TQLE_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: hdl/tqle_pkg.sv
// shared constants and types of the tabular q-learning engine
// no dependencies
package tqle_pkg;

  localparam int unsigned NUM_STATES  = 16;
  localparam int unsigned NUM_ACTIONS = 4;

  localparam int unsigned STATE_W     = 4;
  localparam int unsigned ACT_W       = 2;
  localparam int unsigned Q_W         = 24;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned STATE_IDX_W = $clog2(NUM_STATES);
  localparam int unsigned ACT_IDX_W   = $clog2(NUM_ACTIONS);
  localparam int unsigned Q_ROW_W     = NUM_ACTIONS * Q_W;
  localparam int unsigned V_ROW_W     = NUM_ACTIONS * CNT_W;

  localparam int Q_ONE    = 4096;
  localparam int Q_DIAG_N = 3;

  localparam logic [FRAC_W-1:0] LEARN_RATE_RST   = 16'd6554;
  localparam logic [FRAC_W-1:0] DISCOUNT_RST     = 16'd58982;
  localparam logic [FRAC_W-1:0] EXPLORE_RATE_RST = 16'd58982;

  localparam logic OP_SELECT = 1'b0;
  localparam logic OP_LEARN  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARN_RATE   = 2'd0,
    REG_DISCOUNT     = 2'd1,
    REG_EXPLORE_RATE = 2'd2,
    REG_EXPLORE_EN   = 2'd3
  } cfg_reg_e;

  typedef logic [NUM_ACTIONS-1:0][Q_W-1:0]   q_row_t;
  typedef logic [NUM_ACTIONS-1:0][CNT_W-1:0] v_row_t;

endpackage

FILE: hdl/tabular_q_learning_engine.sv
// select: registered row read, then the result register; the next item waits until it is loaded
// learn: no new item is taken until write-back; each item goes through two
//   reads of the single-read-port q row memory followed by two multiply stages and write-back
// reset clears config to defaults and the row valid bits; unwritten rows read as reset contents
// no clearing pass after reset; depends on tqle_pkg, tqle_row_ram, tqle_learn
`include "tabular_q_learning_engine_macros.svh"
module tabular_q_learning_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tqle_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tqle_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                action_i,
  input  logic [tqle_pkg::STATE_W-1:0]        current_state_i,
  input  logic [tqle_pkg::ACT_W-1:0]          taken_action_i,
  input  logic [tqle_pkg::STATE_W-1:0]        next_state_i,
  input  logic signed [tqle_pkg::Q_W-1:0]     reward_i,
  input  logic [tqle_pkg::FRAC_W-1:0]         rand_draw_i,
  input  logic [tqle_pkg::FRAC_W-1:0]         rand_pick_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tqle_pkg::ACT_W-1:0]          chosen_action_o,
  output logic                                explored_o,
  output logic signed [tqle_pkg::Q_W-1:0]     q_value_o,
  output logic [tqle_pkg::CNT_W-1:0]          visit_count_o
);
  import tqle_pkg::*;

  localparam int unsigned PICK_W = FRAC_W + $clog2(NUM_ACTIONS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD1  = 4'b0010,
    ST_RD2  = 4'b0100,
    ST_UPD  = 4'b1000
  } state_e;

  function automatic q_row_t reset_row(input logic [STATE_IDX_W-1:0] s);
    q_row_t r;
    r = '0;
    for (int a = 0; a < NUM_ACTIONS; a++) begin
      if (a < Q_DIAG_N && int'(s) == a) begin
        r[a] = Q_W'(Q_ONE);
      end
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [FRAC_W-1:0] learn_rate_q, discount_q, explore_rate_q;
  logic              explore_en_q;

  logic                     op_q, ok_q;
  logic [STATE_W-1:0]       s0_q;
  logic [ACT_W-1:0]         act_q;
  logic signed [Q_W-1:0]    reward_q;
  logic [FRAC_W-1:0]        draw_q, pick_q;
  logic signed [Q_W-1:0]    max_q_q;
  logic [STATE_IDX_W-1:0]   row_addr_q;

  logic                     in_acc, in_ok, out_free, out_load, max_load, learn_load;
  logic                     q_rd_en, q_wr_en, q_rd_valid, v_rd_valid;
  logic [STATE_IDX_W-1:0]   rd_addr, s0_idx;
  logic [Q_ROW_W-1:0]       q_rd_data;
  logic [V_ROW_W-1:0]       v_rd_data;
  q_row_t                   q_row, q_wr_row;
  v_row_t                   v_row, v_wr_row;
  logic [ACT_IDX_W-1:0]     act_idx;
  logic [ACT_W-1:0]         best_a;
  logic signed [Q_W-1:0]    best_v;
  logic                     explore_hit;
  logic [PICK_W-1:0]        pick_prod;
  logic signed [Q_W-1:0]    new_q;
  logic [CNT_W-1:0]         cnt_old, cnt_new;

  logic                     out_valid_q;
  logic [ACT_W-1:0]         chosen_q, chosen_d;
  logic                     explored_q, explored_d;
  logic signed [Q_W-1:0]    qv_q, qv_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_rate_q   <= LEARN_RATE_RST;
      discount_q     <= DISCOUNT_RST;
      explore_rate_q <= EXPLORE_RATE_RST;
      explore_en_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_LEARN_RATE:   learn_rate_q   <= cfg_data_i;
        REG_DISCOUNT:     discount_q     <= cfg_data_i;
        REG_EXPLORE_RATE: explore_rate_q <= cfg_data_i;
        REG_EXPLORE_EN:   explore_en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input transfer and item registers
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    in_ok = ({1'b0, current_state_i} < (STATE_W + 1)'(NUM_STATES));
    if (action_i == OP_LEARN) begin
      in_ok = in_ok && ({1'b0, next_state_i} < (STATE_W + 1)'(NUM_STATES))
                    && ({1'b0, taken_action_i} < (ACT_W + 1)'(NUM_ACTIONS));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_SELECT;
      ok_q <= 1'b0;
    end else if (in_acc) begin
      op_q <= action_i;
      ok_q <= in_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s0_q     <= current_state_i;
      act_q    <= taken_action_i;
      reward_q <= reward_i;
      draw_q   <= rand_draw_i;
      pick_q   <= rand_pick_i;
    end
    if (max_load) begin
      max_q_q <= best_v;
    end
    if (q_rd_en) begin
      row_addr_q <= rd_addr;
    end
  end

  // row memories
  assign s0_idx  = STATE_IDX_W'(s0_q);
  assign act_idx = ACT_IDX_W'(act_q);

  always_comb begin
    if (state_q == ST_IDLE) begin
      rd_addr = STATE_IDX_W'((action_i == OP_LEARN) ? next_state_i : current_state_i);
    end else begin
      rd_addr = s0_idx;
    end
  end

  assign q_rd_en = in_acc || max_load;

  tqle_row_ram #(
    .DEPTH(NUM_STATES),
    .WIDTH(Q_ROW_W)
  ) u_q_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (q_rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (q_rd_data),
    .rd_valid_o (q_rd_valid),
    .wr_en_i    (q_wr_en),
    .wr_addr_i  (s0_idx),
    .wr_data_i  (q_wr_row)
  );

  tqle_row_ram #(
    .DEPTH(NUM_STATES),
    .WIDTH(V_ROW_W)
  ) u_v_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (max_load),
    .rd_addr_i  (s0_idx),
    .rd_data_o  (v_rd_data),
    .rd_valid_o (v_rd_valid),
    .wr_en_i    (q_wr_en),
    .wr_addr_i  (s0_idx),
    .wr_data_i  (v_wr_row)
  );

  always_comb begin
    if (!ok_q) begin
      q_row = '0;
    end else if (q_rd_valid) begin
      q_row = q_row_t'(q_rd_data);
    end else begin
      q_row = reset_row(row_addr_q);
    end
    v_row = v_rd_valid ? v_row_t'(v_rd_data) : '0;
  end

  // greedy choice, lowest index wins ties; exploration hit and random pick
  always_comb begin
    best_a = '0;
    best_v = $signed(q_row[0]);
    for (int a = 1; a < NUM_ACTIONS; a++) begin
      if ($signed(q_row[a]) > best_v) begin
        best_v = $signed(q_row[a]);
        best_a = ACT_W'(a);
      end
    end
    explore_hit = explore_en_q && (draw_q < explore_rate_q);
    pick_prod   = PICK_W'(pick_q) * PICK_W'(NUM_ACTIONS);
  end

  tqle_learn u_learn (
    .clk_i        (clk_i),
    .load_i       (learn_load),
    .discount_i   (discount_q),
    .learn_rate_i (learn_rate_q),
    .max_q_i      (max_q_q),
    .reward_i     (reward_q),
    .q_old_i      ($signed(q_row[act_idx])),
    .new_q_o      (new_q)
  );

  always_comb begin
    cnt_old  = v_row[act_idx];
    cnt_new  = (&cnt_old) ? cnt_old : cnt_old + CNT_W'(1);
    q_wr_row = q_row;
    q_wr_row[act_idx] = new_q;
    v_wr_row = v_row;
    v_wr_row[act_idx] = cnt_new;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    out_load   = 1'b0;
    max_load   = 1'b0;
    learn_load = 1'b0;
    q_wr_en    = 1'b0;
    chosen_d   = '0;
    explored_d = 1'b0;
    qv_d       = '0;
    cnt_d      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_RD1;
        end
      end
      ST_RD1: begin
        if (op_q == OP_LEARN && ok_q) begin
          max_load = 1'b1;
          state_d  = ST_RD2;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (op_q == OP_SELECT) begin
            chosen_d   = explore_hit ? pick_prod[FRAC_W +: ACT_W] : best_a;
            explored_d = explore_hit;
          end
        end
      end
      ST_RD2: begin
        learn_load = 1'b1;
        state_d    = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          q_wr_en  = 1'b1;
          out_load = 1'b1;
          qv_d     = new_q;
          cnt_d    = cnt_new;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      chosen_q   <= chosen_d;
      explored_q <= explored_d;
      qv_q       <= qv_d;
      cnt_q      <= cnt_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chosen_action_o = chosen_q;
  assign explored_o      = explored_q;
  assign q_value_o       = qv_q;
  assign visit_count_o   = cnt_q;

  `TQLE_ASSERT(a_wr_only_in_upd, q_wr_en |-> (state_q == ST_UPD) && out_free, "bad write")
  `TQLE_ASSERT_NEXT(a_accept_starts_read, in_acc, state_q == ST_RD1, "accept without read")
  `TQLE_ASSERT_NEXT(a_second_read_s0, max_load, row_addr_q == s0_idx, "wrong learn row")
  `TQLE_ASSERT_NEXT(a_visit_bumped, q_wr_en, out_valid_o && (visit_count_o != '0), "no count")

endmodule

FILE: hdl/tqle_row_ram.sv
// generic single-port-read, single-port-write row memory with per-row valid bits
// registered read; no package dependency
module tqle_row_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 96
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  output logic                     rd_valid_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;
  logic [DEPTH-1:0] vld_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o  = rd_data_q;
  assign rd_valid_o = rd_valid_q;

endmodule

FILE: hdl/tqle_learn.sv
// q-value update datapath: discounted target, then rate-scaled step and saturation
// depends on tqle_pkg
module tqle_learn (
  input  logic                                  clk_i,
  input  logic                                  load_i,
  input  logic [tqle_pkg::FRAC_W-1:0]           discount_i,
  input  logic [tqle_pkg::FRAC_W-1:0]           learn_rate_i,
  input  logic signed [tqle_pkg::Q_W-1:0]       max_q_i,
  input  logic signed [tqle_pkg::Q_W-1:0]       reward_i,
  input  logic signed [tqle_pkg::Q_W-1:0]       q_old_i,
  output logic signed [tqle_pkg::Q_W-1:0]       new_q_o
);
  import tqle_pkg::*;

  localparam int unsigned DPROD_W = FRAC_W + 1 + Q_W;
  localparam int unsigned T_W     = Q_W + 2;
  localparam int unsigned DIFF_W  = T_W + 1;
  localparam int unsigned LPROD_W = FRAC_W + 1 + DIFF_W;
  localparam int unsigned U_W     = LPROD_W - FRAC_W;
  localparam int unsigned NQ_W    = U_W + 1;

  localparam logic signed [NQ_W-1:0] SAT_HI = NQ_W'(2 ** (Q_W - 1) - 1);
  localparam logic signed [NQ_W-1:0] SAT_LO = NQ_W'(-(2 ** (Q_W - 1)));
  localparam logic signed [Q_W-1:0]  Q_HI   = {1'b0, {(Q_W - 1){1'b1}}};
  localparam logic signed [Q_W-1:0]  Q_LO   = {1'b1, {(Q_W - 1){1'b0}}};

  logic signed [DPROD_W-1:0] disc_prod;
  logic signed [T_W-1:0]     t_d, t_q;
  logic signed [Q_W-1:0]     q_old_q;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [LPROD_W-1:0] lprod;
  logic signed [U_W-1:0]     step;
  logic signed [NQ_W-1:0]    nq;

  always_comb begin
    disc_prod = $signed({1'b0, discount_i}) * max_q_i;
    t_d       = T_W'(reward_i) + T_W'(disc_prod >>> FRAC_W);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      t_q     <= t_d;
      q_old_q <= q_old_i;
    end
  end

  always_comb begin
    diff  = DIFF_W'(t_q) - DIFF_W'(q_old_q);
    lprod = $signed({1'b0, learn_rate_i}) * diff;
    step  = U_W'(lprod >>> FRAC_W);
    nq    = NQ_W'(q_old_q) + NQ_W'(step);
    priority if (nq > SAT_HI) begin
      new_q_o = Q_HI;
    end else if (nq < SAT_LO) begin
      new_q_o = Q_LO;
    end else begin
      new_q_o = Q_W'(nq);
    end
  end

endmodule
